[rtl/sha_pkg.sv]
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    localparam logic [31:0] INIT_VECTOR [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[rtl/sha_buf_ram.sv]
module sha_buf_ram
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        wr_en,
    input  logic [3:0]  wr_word,
    input  logic [1:0]  wr_lane,
    input  logic [7:0]  wr_data,
    input  logic [3:0]  rd_word,
    output logic [31:0] rd_data
);

    logic [7:0] mem_b0 [16];
    logic [7:0] mem_b1 [16];
    logic [7:0] mem_b2 [16];
    logic [7:0] mem_b3 [16];

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_lane == 2'd0)
        begin
            mem_b0[wr_word] <= wr_data;
        end
        if (wr_en && wr_lane == 2'd1)
        begin
            mem_b1[wr_word] <= wr_data;
        end
        if (wr_en && wr_lane == 2'd2)
        begin
            mem_b2[wr_word] <= wr_data;
        end
        if (wr_en && wr_lane == 2'd3)
        begin
            mem_b3[wr_word] <= wr_data;
        end
        rd_data <= {mem_b0[rd_word], mem_b1[rd_word], mem_b2[rd_word], mem_b3[rd_word]};
    end

endmodule

[rtl/sha_round.sv]
module sha_round
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        fold,
    input  logic        reinit,
    input  logic        step,
    input  logic [5:0]  round,
    input  logic [31:0] msg_word,
    input  logic [2:0]  out_sel,
    output logic [31:0] hash_out
);

    logic [31:0] hash_reg [8];
    logic [31:0] var_reg [8];
    logic [31:0] win_reg [16];
    logic [31:0] w_now, s0, s1, t1, t2, a, e, w2, w7, w15, w16;

    assign w2  = win_reg[14];
    assign w7  = win_reg[9];
    assign w15 = win_reg[1];
    assign w16 = win_reg[0];
    assign s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    assign s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    assign w_now = (round < 6'd16) ? msg_word : (s1 + w7 + s0 + w16);
    assign a = var_reg[0];
    assign e = var_reg[4];
    assign t1 = var_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & var_reg[5]) ^ (~e & var_reg[6])) + ROUND_K[round] + w_now;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & var_reg[1]) ^ (a & var_reg[2]) ^ (var_reg[1] & var_reg[2]));
    assign hash_out = hash_reg[out_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INIT_VECTOR[i];
            end
        end
        else if (reinit)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INIT_VECTOR[i];
            end
        end
        else if (fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_reg[i] + var_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                var_reg[i] <= hash_reg[i];
            end
        end
        else if (step)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_now;
        end
    end

endmodule

[rtl/sha256_byte_stream_hasher.sv]
// Channel  Direction  Payload    Handshake
// in       input      sha_in_t   in_valid / in_ready
// out      output     sha_out_t  out_valid / out_ready
//
// Each accepted byte is written to the block memory.
// The 64th byte starts a compression: a load step that reads the first word, 64 rounds, then a fold.
// The end mark pads through the same memory port, one byte a cycle, then compresses once or twice.
// Eight digest words follow, one per transfer; out_ready stalls them.
// Reset loads the initial hash vector and clears the counters.
module sha256_byte_stream_hasher
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sha_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output sha_out_t out_data
);

    sha_state_t state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] total_reg, total_next;
    logic        fin_reg, fin_next;
    logic        mark_reg, mark_next;
    logic        lblk_reg, lblk_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  widx_reg, widx_next;

    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic [3:0]  rd_word;
    logic [31:0] rd_data;
    logic        start, fold, reinit, step;
    logic [7:0]  len_byte;

    assign len_byte = 8'(total_reg >> {~fill_reg[2:0], 3'd0});

    sha_buf_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_word (wr_addr[5:2]),
        .wr_lane (wr_addr[1:0]),
        .wr_data (wr_data),
        .rd_word (rd_word),
        .rd_data (rd_data)
    );

    sha_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .fold     (fold),
        .reinit   (reinit),
        .step     (step),
        .round    (cnt_reg),
        .msg_word (rd_data),
        .out_sel  (widx_reg),
        .hash_out (out_data.digest_word)
    );

    assign out_data.word_index = widx_reg;
    assign out_data.last_word  = (widx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            total_reg <= '0;
            fin_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            lblk_reg  <= 1'b0;
            cnt_reg   <= '0;
            widx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            total_reg <= total_next;
            fin_reg   <= fin_next;
            mark_reg  <= mark_next;
            lblk_reg  <= lblk_next;
            cnt_reg   <= cnt_next;
            widx_reg  <= widx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        total_next = total_reg;
        fin_next   = fin_reg;
        mark_next  = mark_reg;
        lblk_next  = lblk_reg;
        cnt_next   = cnt_reg;
        widx_next  = widx_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = fill_reg;
        wr_data    = in_data.data_byte;
        rd_word    = cnt_reg[3:0];
        start      = 1'b0;
        fold       = 1'b0;
        reinit     = 1'b0;
        step       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.has_byte)
                    begin
                        wr_en = 1'b1;
                        fill_next = fill_reg + 6'd1;
                    end
                    if (in_data.end_of_message)
                    begin
                        fin_next = 1'b1;
                        mark_next = 1'b1;
                        lblk_next = 1'b0;
                        total_next = len_reg
                            + {54'd0, ({1'b0, fill_reg} + 7'(in_data.has_byte)), 3'd0};
                        state_next = ST_PAD;
                    end
                    if (in_data.has_byte && fill_reg == 6'd63)
                    begin
                        len_next = len_reg + 64'd512;
                        cnt_next = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_PAD:
            begin
                wr_en = 1'b1;
                fill_next = fill_reg + 6'd1;
                mark_next = 1'b0;
                lblk_next = lblk_reg | (mark_reg && fill_reg < 6'd56);
                priority if (mark_reg)
                begin
                    wr_data = PAD_BYTE;
                end
                else if (lblk_reg && fill_reg >= 6'd56)
                begin
                    wr_data = len_byte;
                end
                else
                begin
                    wr_data = 8'd0;
                end
                if (fill_reg == 6'd63)
                begin
                    cnt_next = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                rd_word = 4'd0;
                start = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                step = 1'b1;
                rd_word = 4'(cnt_reg[3:0] + 4'd1);
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                fold = 1'b1;
                widx_next = '0;
                priority if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (lblk_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    lblk_next = 1'b1;
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == 3'd7)
                    begin
                        reinit = 1'b1;
                        fill_next = '0;
                        len_next = '0;
                        fin_next = 1'b0;
                        mark_next = 1'b0;
                        lblk_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_EMIT) else $error("out_valid outside emit");
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("input taken during output");
    a_round_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |=> state_reg == ST_ROUND && cnt_reg == 6'd0)
        else $error("bad round start");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");
`endif

endmodule
